FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha256_pkg.sv
// Types, constants and a helper function of the SHA-256 byte stream hasher.
package sha256_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Controls from the sequencer to the round unit.
    typedef struct packed {
        logic init;
        logic step;
        logic fold;
        logic restart;
    } t_rnd_ctrl;

    // Controls from the sequencer to the schedule window.
    typedef struct packed {
        logic       push;
        logic [7:0] byte_val;
        logic       step;
        logic       expand;
    } t_sch_ctrl;

    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [5:0] LenFill     = 6'd56;
    localparam logic [5:0] LastFill    = 6'd63;
    localparam logic [5:0] LastRound   = 6'd63;
    localparam logic [3:0] LenBytes    = 4'd8;
    localparam logic [2:0] LastWordIdx = 3'd7;

    localparam t_word InitH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

FILE: rtl/sha256_sched.sv
// Message schedule window: collects block bytes and expands schedule words.
module sha256_sched (
    input  logic                  i_clk,
    input  sha256_pkg::t_sch_ctrl i_ctrl,
    output sha256_pkg::t_word     o_w
);

    // Word i of the window sits at bits [511-32*i -: 32]; word 0 is the oldest.
    logic [511:0] r_win;
    logic [511:0] n_win;

    sha256_pkg::t_word w0;
    sha256_pkg::t_word w1;
    sha256_pkg::t_word w9;
    sha256_pkg::t_word w14;
    sha256_pkg::t_word s0;
    sha256_pkg::t_word s1;

    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];

    assign s0 = sha256_pkg::rotr(w1, 7) ^ sha256_pkg::rotr(w1, 18) ^ (w1 >> 3);
    assign s1 = sha256_pkg::rotr(w14, 17) ^ sha256_pkg::rotr(w14, 19) ^ (w14 >> 10);

    // In the first sixteen rounds the window simply rotates the loaded words.
    assign o_w = i_ctrl.expand ? (w0 + s0 + w9 + s1) : w0;

    always_comb begin
        n_win = r_win;
        if (i_ctrl.push) begin
            n_win = {r_win[503:0], i_ctrl.byte_val};
        end else if (i_ctrl.step) begin
            n_win = {r_win[479:0], o_w};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

FILE: rtl/sha256_round.sv
// Shared round unit: working variables, chaining value and the final fold.
module sha256_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_rnd_ctrl i_ctrl,
    input  logic [5:0]            i_round,
    input  sha256_pkg::t_word     i_w,
    input  logic [2:0]            i_rd_index,
    output sha256_pkg::t_word     o_digest_word
);

    sha256_pkg::t_word r_h [0:7];
    sha256_pkg::t_word r_v [0:7];

    sha256_pkg::t_word big_s1;
    sha256_pkg::t_word big_s0;
    sha256_pkg::t_word ch;
    sha256_pkg::t_word maj;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;

    assign big_s1 = sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
                  ^ sha256_pkg::rotr(r_v[4], 25);
    assign big_s0 = sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
                  ^ sha256_pkg::rotr(r_v[0], 22);
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_s1 + ch + sha256_pkg::RoundK[i_round] + i_w;
    assign t2  = big_s0 + maj;

    assign o_digest_word = r_h[i_rd_index];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= sha256_pkg::InitH;
        end else if (i_ctrl.restart) begin
            r_h <= sha256_pkg::InitH;
        end else if (i_ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_v <= r_h;
        end else if (i_ctrl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule

FILE: rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: sequencer, counters and ports.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | i_valid / o_ready  | i_data_byte, i_byte_present, i_end_message
//  out     | o_valid / i_ready  | o_digest_word, o_word_index, o_last_word
//
// An item that neither completes a block nor ends the message leaves the block ready for the next item.
// An item that completes a 64-byte block loads the last byte, runs 64 rounds through
// the single round unit and folds into the chaining value before the next item is taken.
// An ending item adds 9 to 72 padding bytes, one or two more compressions, and eight
// digest words, each held on the outputs for as long as i_ready is low.
// Reset returns the chaining value, byte count and bit length to their initial values.
module sha256_byte_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state r_state;
    sha256_pkg::t_state n_state;
    logic [5:0]         r_fill;
    logic [5:0]         n_fill;
    logic [63:0]        r_bits;
    logic [63:0]        n_bits;
    logic [5:0]         r_round;
    logic [5:0]         n_round;
    logic               r_padding;
    logic               n_padding;
    logic               r_sent80;
    logic               n_sent80;
    logic [3:0]         r_len_cnt;
    logic [3:0]         n_len_cnt;
    logic [2:0]         r_word_idx;
    logic [2:0]         n_word_idx;

    sha256_pkg::t_sch_ctrl sch_ctrl;
    sha256_pkg::t_rnd_ctrl rnd_ctrl;
    sha256_pkg::t_word     sched_w;
    logic                  len_phase;
    logic [7:0]            len_byte;

    // The length goes out most significant byte first.
    assign len_byte  = r_bits[{~r_len_cnt[2:0], 3'b000} +: 8];
    assign len_phase = r_sent80 && ((r_fill == sha256_pkg::LenFill) || (r_len_cnt != 4'd0));

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_round    = r_round;
        n_padding  = r_padding;
        n_sent80   = r_sent80;
        n_len_cnt  = r_len_cnt;
        n_word_idx = r_word_idx;
        sch_ctrl   = '0;
        rnd_ctrl   = '0;
        o_ready    = 1'b0;
        o_valid    = 1'b0;

        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_padding = i_end_message;
                    if (i_byte_present) begin
                        sch_ctrl.push     = 1'b1;
                        sch_ctrl.byte_val = i_data_byte;
                        n_fill            = r_fill + 6'd1;
                        n_bits            = r_bits + 64'd8;
                        if (r_fill == sha256_pkg::LastFill) begin
                            rnd_ctrl.init = 1'b1;
                            n_round       = 6'd0;
                            n_state       = sha256_pkg::ST_ROUND;
                        end else if (i_end_message) begin
                            n_state = sha256_pkg::ST_PAD;
                        end
                    end else if (i_end_message) begin
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_ROUND: begin
                sch_ctrl.step   = 1'b1;
                sch_ctrl.expand = (r_round[5:4] != 2'd0);
                rnd_ctrl.step   = 1'b1;
                n_round         = r_round + 6'd1;
                if (r_round == sha256_pkg::LastRound) begin
                    n_state = sha256_pkg::ST_FINAL;
                end
            end
            sha256_pkg::ST_FINAL: begin
                rnd_ctrl.fold = 1'b1;
                if (!r_padding) begin
                    n_state = sha256_pkg::ST_IDLE;
                end else if (r_len_cnt == sha256_pkg::LenBytes) begin
                    n_word_idx = 3'd0;
                    n_state    = sha256_pkg::ST_EMIT;
                end else begin
                    n_state = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD: begin
                sch_ctrl.push = 1'b1;
                if (!r_sent80) begin
                    sch_ctrl.byte_val = sha256_pkg::PadByte;
                end else if (len_phase) begin
                    sch_ctrl.byte_val = len_byte;
                    n_len_cnt         = r_len_cnt + 4'd1;
                end else begin
                    sch_ctrl.byte_val = 8'h00;
                end
                n_sent80 = 1'b1;
                n_fill   = r_fill + 6'd1;
                if (r_fill == sha256_pkg::LastFill) begin
                    rnd_ctrl.init = 1'b1;
                    n_round       = 6'd0;
                    n_state       = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_word_idx = r_word_idx + 3'd1;
                    if (r_word_idx == sha256_pkg::LastWordIdx) begin
                        rnd_ctrl.restart = 1'b1;
                        n_bits           = 64'd0;
                        n_fill           = 6'd0;
                        n_padding        = 1'b0;
                        n_sent80         = 1'b0;
                        n_len_cnt        = 4'd0;
                        n_state          = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_IDLE;
            r_fill     <= 6'd0;
            r_bits     <= 64'd0;
            r_round    <= 6'd0;
            r_padding  <= 1'b0;
            r_sent80   <= 1'b0;
            r_len_cnt  <= 4'd0;
            r_word_idx <= 3'd0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_bits     <= n_bits;
            r_round    <= n_round;
            r_padding  <= n_padding;
            r_sent80   <= n_sent80;
            r_len_cnt  <= n_len_cnt;
            r_word_idx <= n_word_idx;
        end
    end

    sha256_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sch_ctrl),
        .o_w    (sched_w)
    );

    sha256_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (rnd_ctrl),
        .i_round       (r_round),
        .i_w           (sched_w),
        .i_rd_index    (r_word_idx),
        .o_digest_word (o_digest_word)
    );

    assign o_word_index = r_word_idx;
    assign o_last_word  = (r_word_idx == sha256_pkg::LastWordIdx);

endmodule

FILE: rtl/sha256_checker.sv
// Port-level checker for the hasher, bound to its top level.
`include "assert_macros.svh"

module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // The block never takes an item while a digest is being delivered.
    `ASSERT_IMPLY(a_no_overlap, i_clk, i_rst_n, o_ready, !o_valid, "ready while digest pending")

    // The last-word flag marks exactly the eighth word.
    `ASSERT_IMPLY(a_last_flag, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd7), "last_word out of step with word_index")

    // Digest words follow one another in order.
    `ASSERT_NEXT(a_word_order, i_clk, i_rst_n, o_valid && i_ready && !o_last_word, o_valid && (o_word_index == $past(o_word_index) + 3'd1), "digest words out of order")

    // A word that is not taken stays on the outputs unchanged.
    `ASSERT_NEXT(a_hold_word, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word) && $stable(o_word_index), "digest word changed while stalled")

    // Once the final word is taken the block is ready for the next message.
    `ASSERT_NEXT(a_ready_after, i_clk, i_rst_n, o_valid && i_ready && o_last_word, o_ready && !o_valid, "not ready after digest")

endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_sha256_checker (.*);

FILE: tb/sha256_digest_track_pkg.sv
// Round constants, digest word type and the digest tracking scoreboard for the hasher bench.
package sha256_digest_track_pkg;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [7:0]  PAD_MARK  = 8'h80;
    localparam int        LEN_START = 56;
    localparam int        MAX_WORDS = 10;

    function automatic bit [31:0] rotate_right(bit [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    class sha256_digest_tracker;
        bit [31:0]    chain [8];
        bit [7:0]     blk_bytes [64];
        int unsigned  fill;
        bit [63:0]    bit_count;
        t_digest_word owed_words [$];
        int unsigned  mismatches;
        int unsigned  words_seen;
        int unsigned  messages;
        int unsigned  msg_bytes;
        int unsigned  ignored;

        function new();
            restart();
            mismatches = 0;
            words_seen = 0;
            messages   = 0;
            msg_bytes  = 0;
            ignored    = 0;
        endfunction

        function void restart();
            chain     = START_HASH;
            fill      = 0;
            bit_count = '0;
        endfunction

        function void compress();
            bit [31:0] w [16];
            bit [31:0] v [8];
            bit [31:0] s0, s1, wt, t1, t2;
            int i, t;
            for (i = 0; i < 16; i++)
                w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
            v = chain;
            for (t = 0; t < 64; t++) begin
                if (t < 16) begin
                    wt = w[t];
                end else begin
                    s0 = rotate_right(w[(t-15)%16], 7) ^ rotate_right(w[(t-15)%16], 18)
                         ^ (w[(t-15)%16] >> 3);
                    s1 = rotate_right(w[(t-2)%16], 17) ^ rotate_right(w[(t-2)%16], 19)
                         ^ (w[(t-2)%16] >> 10);
                    wt = w[t%16] + s0 + w[(t-7)%16] + s1;
                    w[t%16] = wt;
                end
                t1 = v[7] + (rotate_right(v[4], 6) ^ rotate_right(v[4], 11)
                     ^ rotate_right(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                     + ROUND_CONST[t] + wt;
                t2 = (rotate_right(v[0], 2) ^ rotate_right(v[0], 13) ^ rotate_right(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void absorb(bit [7:0] b);
            blk_bytes[fill] = b;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        // Called for every accepted input item; an ending item queues the eight digest words.
        function void note_item(logic [7:0] data, logic present, logic ending);
            bit [63:0] len;
            t_digest_word dw;
            int k;
            if (present) begin
                absorb(data);
                bit_count += 64'd8;
                msg_bytes++;
            end else if (!ending) begin
                ignored++;
            end
            if (ending) begin
                len = bit_count;
                absorb(PAD_MARK);
                while (fill != LEN_START)
                    absorb(8'h00);
                for (k = 0; k < 8; k++)
                    absorb(len[8*(7-k) +: 8]);
                for (k = 0; k < 8; k++) begin
                    dw.word  = chain[k];
                    dw.index = k[2:0];
                    dw.last  = (k == 7);
                    owed_words = {owed_words, dw};
                end
                messages++;
                restart();
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_WORDS)
                $display("MISMATCH: %s", what);
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] index, logic last);
            t_digest_word want;
            words_seen++;
            if (owed_words.size() == 0) begin
                flag($sformatf("unexpected digest word %h index %0d last %b", word, index, last));
            end else begin
                want = owed_words.pop_front();
                if (word !== want.word || index !== want.index || last !== want.last)
                    flag($sformatf("expected word %h index %0d last %b, got %h index %0d last %b",
                                   want.word, want.index, want.last, word, index, last));
            end
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction
    endclass

endpackage

FILE: tb/sha256_byte_stream_hasher_core_tb.sv
// Self-checking bench for the SHA-256 byte stream hasher with random handshake stalls.
module sha256_byte_stream_hasher_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 100;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [7:0]         i_data_byte    = 8'h00;
    logic               i_byte_present = 1'b0;
    logic               i_end_message  = 1'b0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    sha256_pkg::t_word  o_digest_word;
    logic [2:0]         o_word_index;
    logic               o_last_word;

    sha256_digest_track_pkg::sha256_digest_tracker digests;
    bit                   calm = 1'b0;
    int unsigned          stim_items = 0;
    int unsigned          cycle_count = 0;

    sha256_byte_stream_hasher_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_message  (i_end_message),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sha256_byte_stream_hasher_core_tb: FAIL");
        $finish;
    end

    // Receiver side: bursts of stalls between stretches of readiness.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            digests.check_word(o_digest_word, o_word_index, o_last_word);
    end

    // Presents one item, optionally after an idle burst, and returns at the edge that takes it.
    task automatic send_item(input logic [7:0] data, input logic present, input logic ending,
                             input bit quiet);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= data;
        i_byte_present <= present;
        i_end_message  <= ending;
        do @(posedge i_clk); while (!o_ready);
        digests.note_item(data, present, ending);
        stim_items++;
    endtask

    task automatic send_message(input int unsigned len);
        bit quiet;
        bit merge_end;
        int unsigned n;
        quiet     = calm || ($urandom_range(0, 2) == 0);
        merge_end = (len != 0) && ($urandom_range(0, 1) == 1);
        for (n = 0; n < len; n++) begin
            if (!calm && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, quiet);
            send_item(8'($urandom), 1'b1, merge_end && (n == len - 1), quiet);
        end
        if (!merge_end)
            send_item(8'($urandom), 1'b0, 1'b1, quiet);
    endtask

    // Holds the sender off until every outstanding digest word has been seen.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (digests.pending() != 0);
    endtask

    initial begin
        digests = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, with a stray data value that must be ignored.
        send_item(8'hA5, 1'b0, 1'b1, 1'b1);
        // Single byte ending on the same item, at both extremes of the byte.
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        // "abc" with an ignored item in front and a separate ending item.
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        // Another empty message straight after a digest.
        send_item(8'hC3, 1'b0, 1'b1, 1'b1);
        drain();

        // A full block, ended either on its last byte or by a separate item.
        send_message(64);

        while (stim_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                send_message($urandom_range(13, 70));
            else
                send_message($urandom_range(0, 12));
        end
        drain();

        calm = 1'b1;
        repeat (2) send_message($urandom_range(0, 10));

        i_valid <= 1'b0;
        do @(posedge i_clk); while (digests.pending() != 0);
        repeat (200) @(posedge i_clk);

        $display("Hashed %0d messages from %0d bytes, with %0d ignored items in between.",
                 digests.messages, digests.msg_bytes, digests.ignored);
        $display("Checked %0d digest words, %0d mismatches.",
                 digests.words_seen, digests.mismatches);
        if (digests.mismatches == 0 && digests.pending() == 0)
            $display("sha256_byte_stream_hasher_core_tb: PASS");
        else
            $display("sha256_byte_stream_hasher_core_tb: FAIL");
        $finish;
    end

endmodule
